>>> hw/rtl/rts_pkg.sv
// rts_pkg: shared widths, register indexes and mode codes for the
// RGB565 threshold scaler. No dependencies.
`default_nettype none

package rts_pkg;

    localparam int COORD_W    = 10;  // src/dst column and row
    localparam int PIX_W      = 16;  // RGB565 pixel
    localparam int DIM_REG_W  = 11;  // dimension registers
    localparam int MODE_W     = 2;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int LUMA_W     = 12;  // 3R + 6G + B peaks at 2504

    localparam logic [4:0] RED_MASK   = 5'h1F;
    localparam logic [5:0] GREEN_MASK = 6'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISPLAY_WIDTH  = 3'd0,
        REG_DISPLAY_HEIGHT = 3'd1,
        REG_SOURCE_WIDTH   = 3'd2,
        REG_SOURCE_HEIGHT  = 3'd3,
        REG_SCALE_MODE     = 3'd4,
        REG_LUMA_THRESHOLD = 3'd5
    } t_cfg_reg;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE = 2'd0,
        MODE_FILL = 2'd1,
        MODE_FIT  = 2'd2
    } t_mode;

endpackage

`default_nettype wire

>>> hw/rtl/rts_if.sv
// rts_if: valid/ready channel interfaces for pixels in, dots out and
// register writes. Depends on rts_pkg.
`default_nettype none

interface rts_in_if;
    import rts_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [PIX_W-1:0]   rgb_pixel;

    modport source (output valid, output src_col, output src_row, output rgb_pixel,
                    input ready);
    modport sink   (input valid, input src_col, input src_row, input rgb_pixel,
                    output ready);
endinterface

interface rts_out_if;
    import rts_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] dst_col;
    logic [COORD_W-1:0] dst_row;
    logic               lit;

    modport source (output valid, output dst_col, output dst_row, output lit,
                    input ready);
    modport sink   (input valid, input dst_col, input dst_row, input lit,
                    output ready);
endinterface

interface rts_cfg_if;
    import rts_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rts_divider.sv
// rts_divider: restoring unsigned divider, one quotient bit per cycle.
// Used by rts_setup for the fill scales. No package dependency.
`default_nettype none

module rts_divider #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    logic             ge;

    assign rem_sh   = {r_rem, r_quo[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, r_den};
    assign rem_diff = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

>>> hw/rtl/rts_setup.sv
// rts_setup: register file and the sequencer that derives scales and offsets
// after reset and each write to registers 0 to 5. Uses rts_pkg, rts_divider.
`default_nettype none

module rts_setup #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    rts_cfg_if.sink                  i_cfg,
    output logic                     o_busy,
    output logic [rts_pkg::THR_W-1:0] o_thr,
    output logic [((($clog2(MAX_DIM + 1) < rts_pkg::DIM_REG_W) ?
                   $clog2(MAX_DIM + 1) : rts_pkg::DIM_REG_W))-1:0]
                                     o_src_w, o_src_h, o_disp_w, o_disp_h,
    output logic [((($clog2(MAX_DIM + 1) < rts_pkg::DIM_REG_W) ?
                   $clog2(MAX_DIM + 1) : rts_pkg::DIM_REG_W)) + FRAC_BITS-1:0]
                                     o_scale_h, o_scale_v,
    output logic signed [((($clog2(MAX_DIM + 1) < rts_pkg::DIM_REG_W) ?
                   $clog2(MAX_DIM + 1) : rts_pkg::DIM_REG_W))      :0]
                                     o_off_h, o_off_v
);

    import rts_pkg::*;

    localparam int DIM_W   = ($clog2(MAX_DIM + 1) < DIM_REG_W) ?
                             $clog2(MAX_DIM + 1) : DIM_REG_W;
    localparam int SCALE_W = DIM_W + FRAC_BITS;
    localparam int OFF_W   = DIM_W + 1;
    localparam int USED_W  = DIM_W + SCALE_W;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_LAUNCH_X = 7'b0000010,
        S_WAIT_X   = 7'b0000100,
        S_LAUNCH_Y = 7'b0001000,
        S_WAIT_Y   = 7'b0010000,
        S_MUL      = 7'b0100000,
        S_FIN      = 7'b1000000
    } t_state;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    function automatic logic signed [OFF_W-1:0] fit_offset(
        input logic [DIM_W-1:0]  disp,
        input logic [USED_W-1:0] used
    );
        logic [USED_W-1:0] full;
        logic [USED_W-1:0] diff;
        logic [DIM_W-1:0]  half;
        full = USED_W'(disp) << FRAC_BITS;
        diff = full - used;
        half = diff[FRAC_BITS+1 +: DIM_W];
        return (used >= full) ? '0 : $signed({1'b0, half});
    endfunction

    function automatic logic signed [OFF_W-1:0] centre_offset(
        input logic [DIM_W-1:0] disp,
        input logic [DIM_W-1:0] src
    );
        logic signed [OFF_W-1:0] d;
        logic signed [OFF_W-1:0] adj;
        d   = $signed({1'b0, disp}) - $signed({1'b0, src});
        // round toward zero before halving
        adj = d + $signed(OFF_W'(d[OFF_W-1]));
        return adj >>> 1;
    endfunction

    t_state                 r_state, n_state;
    logic [DIM_REG_W-1:0]   r_disp_w, r_disp_h, r_src_w, r_src_h;
    logic [MODE_W-1:0]      r_mode;
    logic [THR_W-1:0]       r_thr;
    logic [SCALE_W-1:0]     r_fx, r_fy, r_min;
    logic [USED_W-1:0]      r_used_h, r_used_v;
    logic [SCALE_W-1:0]     r_scale_h, r_scale_v;
    logic signed [OFF_W-1:0] r_off_h, r_off_v;

    logic [DIM_W-1:0]   dw, dh, sw, sh;
    logic               cfg_take;
    logic               div_start;
    logic               div_done;
    logic [SCALE_W-1:0] div_num;
    logic [DIM_W-1:0]   div_den;
    logic [SCALE_W-1:0] div_quo;
    logic [SCALE_W-1:0] fit_min;

    assign dw = clamp_dim(r_disp_w);
    assign dh = clamp_dim(r_disp_h);
    assign sw = clamp_dim(r_src_w);
    assign sh = clamp_dim(r_src_h);

    assign i_cfg.ready = (r_state == S_IDLE);
    assign cfg_take    = i_cfg.valid && (r_state == S_IDLE);
    assign div_start   = (r_state == S_LAUNCH_X) || (r_state == S_LAUNCH_Y);
    assign div_num     = (r_state == S_LAUNCH_X) ? (SCALE_W'(dw) << FRAC_BITS)
                                                 : (SCALE_W'(dh) << FRAC_BITS);
    assign div_den     = (r_state == S_LAUNCH_X) ? sw : sh;
    assign fit_min     = (r_fx < r_fy) ? r_fx : r_fy;

    rts_divider #(
        .NUM_W (SCALE_W),
        .DEN_W (DIM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cfg_take && (32'(i_cfg.index) <= 32'(REG_LUMA_THRESHOLD))) begin
                    n_state = S_LAUNCH_X;
                end
            end
            S_LAUNCH_X: n_state = S_WAIT_X;
            S_WAIT_X: begin
                if (div_done) begin
                    n_state = S_LAUNCH_Y;
                end
            end
            S_LAUNCH_Y: n_state = S_WAIT_Y;
            S_WAIT_Y: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LAUNCH_X;
            r_disp_w <= DIM_REG_W'(128);
            r_disp_h <= DIM_REG_W'(64);
            r_src_w  <= DIM_REG_W'(128);
            r_src_h  <= DIM_REG_W'(64);
            r_mode   <= MODE_FIT;
            r_thr    <= THR_W'(128);
        end else begin
            r_state <= n_state;
            if (cfg_take) begin
                case (i_cfg.index)
                    REG_DISPLAY_WIDTH:  r_disp_w <= i_cfg.data;
                    REG_DISPLAY_HEIGHT: r_disp_h <= i_cfg.data;
                    REG_SOURCE_WIDTH:   r_src_w  <= i_cfg.data;
                    REG_SOURCE_HEIGHT:  r_src_h  <= i_cfg.data;
                    REG_SCALE_MODE:     r_mode   <= i_cfg.data[MODE_W-1:0];
                    REG_LUMA_THRESHOLD: r_thr    <= i_cfg.data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_h <= '0;
            r_scale_v <= '0;
            r_off_h   <= '0;
            r_off_v   <= '0;
        end else if (r_state == S_FIN) begin
            case (r_mode)
                MODE_FILL: begin
                    r_scale_h <= r_fx;
                    r_scale_v <= r_fy;
                    r_off_h   <= '0;
                    r_off_v   <= '0;
                end
                MODE_FIT: begin
                    r_scale_h <= r_min;
                    r_scale_v <= r_min;
                    r_off_h   <= fit_offset(dw, r_used_h);
                    r_off_v   <= fit_offset(dh, r_used_v);
                end
                default: begin
                    // none, and the unused code
                    r_scale_h <= SCALE_W'(1) << FRAC_BITS;
                    r_scale_v <= SCALE_W'(1) << FRAC_BITS;
                    r_off_h   <= centre_offset(dw, sw);
                    r_off_v   <= centre_offset(dh, sh);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_WAIT_X) && div_done) begin
            r_fx <= div_quo;
        end
        if ((r_state == S_WAIT_Y) && div_done) begin
            r_fy <= div_quo;
        end
        if (r_state == S_MUL) begin
            r_min    <= fit_min;
            r_used_h <= USED_W'(sw) * USED_W'(fit_min);
            r_used_v <= USED_W'(sh) * USED_W'(fit_min);
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_thr     = r_thr;
    assign o_src_w   = sw;
    assign o_src_h   = sh;
    assign o_disp_w  = dw;
    assign o_disp_h  = dh;
    assign o_scale_h = r_scale_h;
    assign o_scale_v = r_scale_v;
    assign o_off_h   = r_off_h;
    assign o_off_v   = r_off_v;

endmodule

`default_nettype wire

>>> hw/rtl/rts_front.sv
// rts_front: accepts pixels, drops those outside the frame, computes the
// lit flag and the scaled coordinates, pushes them to the queue. Uses rts_pkg.
`default_nettype none

module rts_front #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 16
) (
    rts_in_if.sink                    i_pix,
    input  wire logic                 i_busy,
    input  wire logic                 i_q_ready,
    input  wire logic [rts_pkg::THR_W-1:0] i_thr,
    input  wire logic [((($clog2(MAX_DIM + 1) < rts_pkg::DIM_REG_W) ?
                   $clog2(MAX_DIM + 1) : rts_pkg::DIM_REG_W))-1:0]
                                      i_src_w, i_src_h,
    input  wire logic [((($clog2(MAX_DIM + 1) < rts_pkg::DIM_REG_W) ?
                   $clog2(MAX_DIM + 1) : rts_pkg::DIM_REG_W)) + FRAC_BITS-1:0]
                                      i_scale_h, i_scale_v,
    output logic                      o_push,
    output logic [2*((($clog2(MAX_DIM + 1) < rts_pkg::DIM_REG_W) ?
                   $clog2(MAX_DIM + 1) : rts_pkg::DIM_REG_W))  :0] o_entry
);

    import rts_pkg::*;

    localparam int DIM_W   = ($clog2(MAX_DIM + 1) < DIM_REG_W) ?
                             $clog2(MAX_DIM + 1) : DIM_REG_W;
    localparam int SCALE_W = DIM_W + FRAC_BITS;
    localparam int PROD_W  = COORD_W + SCALE_W;

    logic              accept;
    logic              in_frame;
    logic [PROD_W-1:0] prod_h, prod_v;
    logic [7:0]        red8, green8, blue8;
    logic [LUMA_W-1:0] luma_sum;
    logic [LUMA_W-1:0] lit_level;
    logic              lit;

    assign i_pix.ready = !i_busy && i_q_ready;
    assign accept      = i_pix.valid && i_pix.ready;
    assign in_frame    = (32'(i_pix.src_col) < 32'(i_src_w)) &&
                         (32'(i_pix.src_row) < 32'(i_src_h));

    assign prod_h = PROD_W'(i_pix.src_col) * PROD_W'(i_scale_h);
    assign prod_v = PROD_W'(i_pix.src_row) * PROD_W'(i_scale_v);

    assign red8   = {i_pix.rgb_pixel[15:11] & RED_MASK, 3'b000};
    assign green8 = {i_pix.rgb_pixel[10:5] & GREEN_MASK, 2'b00};
    assign blue8  = {i_pix.rgb_pixel[4:0] & RED_MASK, 3'b000};

    // sum/10 > thr  <=>  sum >= 10*thr + 10
    assign luma_sum  = LUMA_W'(red8) * LUMA_W'(3) + LUMA_W'(green8) * LUMA_W'(6)
                     + LUMA_W'(blue8);
    assign lit_level = LUMA_W'(i_thr) * LUMA_W'(10) + LUMA_W'(10);
    assign lit       = luma_sum >= lit_level;

    assign o_push  = accept && in_frame;
    assign o_entry = {lit, prod_v[FRAC_BITS +: DIM_W], prod_h[FRAC_BITS +: DIM_W]};

endmodule

`default_nettype wire

>>> hw/rtl/rts_queue.sv
// rts_queue: small register FIFO between the front and back halves.
// No package dependency.
`default_nettype none

module rts_queue #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

>>> hw/rtl/rts_back.sv
// rts_back: adds offsets, drops dots off the display, holds the result in
// the output register. Uses rts_pkg.
`default_nettype none

module rts_back #(
    parameter int MAX_DIM = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire logic [2*((($clog2(MAX_DIM + 1) < rts_pkg::DIM_REG_W) ?
                   $clog2(MAX_DIM + 1) : rts_pkg::DIM_REG_W))  :0] i_entry,
    input  wire logic [((($clog2(MAX_DIM + 1) < rts_pkg::DIM_REG_W) ?
                   $clog2(MAX_DIM + 1) : rts_pkg::DIM_REG_W))-1:0]
                                      i_disp_w, i_disp_h,
    input  wire logic signed [((($clog2(MAX_DIM + 1) < rts_pkg::DIM_REG_W) ?
                   $clog2(MAX_DIM + 1) : rts_pkg::DIM_REG_W))      :0]
                                      i_off_h, i_off_v,
    output logic                      o_pop,
    rts_out_if.source                 o_dot
);

    import rts_pkg::*;

    localparam int DIM_W = ($clog2(MAX_DIM + 1) < DIM_REG_W) ?
                           $clog2(MAX_DIM + 1) : DIM_REG_W;
    localparam int TX_W  = DIM_W + 2;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_dst_col, r_dst_row;
    logic               r_lit;

    logic [DIM_W-1:0]   map_h, map_v;
    logic               head_lit;
    logic [TX_W-1:0]    tx, ty;
    logic               on_disp;

    assign map_h    = i_entry[DIM_W-1:0];
    assign map_v    = i_entry[2*DIM_W-1:DIM_W];
    assign head_lit = i_entry[2*DIM_W];

    assign tx = TX_W'(i_off_h) + TX_W'(map_h);
    assign ty = TX_W'(i_off_v) + TX_W'(map_v);

    assign on_disp = !tx[TX_W-1] && (tx[TX_W-2:0] < (TX_W-1)'(i_disp_w)) &&
                     !ty[TX_W-1] && (ty[TX_W-2:0] < (TX_W-1)'(i_disp_h));

    // advance when the output register is empty or being emptied
    assign o_pop = i_q_valid && (!r_out_valid || o_dot.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= on_disp;
        end else if (o_dot.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dst_col <= COORD_W'($unsigned(tx[TX_W-2:0]));
            r_dst_row <= COORD_W'($unsigned(ty[TX_W-2:0]));
            r_lit     <= head_lit;
        end
    end

    assign o_dot.valid   = r_out_valid;
    assign o_dot.dst_col = r_dst_col;
    assign o_dot.dst_row = r_dst_row;
    assign o_dot.lit     = r_lit;

endmodule

`default_nettype wire

>>> hw/rtl/rgb565_threshold_scaler.sv
// rgb565_threshold_scaler: top level; wires setup, front, queue and back.
// Depends on rts_pkg, rts_if, rts_setup, rts_front, rts_queue, rts_back.
//
//   port    dir   carries
//   i_pix   sink  src_col, src_row, rgb_pixel
//   o_dot   src   dst_col, dst_row, lit
//   i_cfg   sink  index, data (register write)
//
// One pixel per cycle sustained while setup is idle and the queue has room; a
// pixel is written to the queue at the edge that accepts it and moves to the
// output register once it heads the queue and the output register is free. After
// reset and after each write to a defined register the setup sequencer runs two
// serial divisions (one quotient bit a cycle) plus a multiply; i_pix and i_cfg
// hold ready low meanwhile. A stalled o_dot fills the two-entry queue, then
// drops i_pix.ready. Pixels outside the frame or off the display give no result.
`default_nettype none

module rgb565_threshold_scaler #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rts_in_if.sink     i_pix,
    rts_out_if.source  o_dot,
    rts_cfg_if.sink    i_cfg
);

    import rts_pkg::*;

    localparam int DIM_W   = ($clog2(MAX_DIM + 1) < DIM_REG_W) ?
                             $clog2(MAX_DIM + 1) : DIM_REG_W;
    localparam int SCALE_W = DIM_W + FRAC_BITS;
    localparam int OFF_W   = DIM_W + 1;
    localparam int ENTRY_W = 2 * DIM_W + 1;

    logic                    busy;
    logic [THR_W-1:0]        thr;
    logic [DIM_W-1:0]        src_w, src_h, disp_w, disp_h;
    logic [SCALE_W-1:0]      scale_h, scale_v;
    logic signed [OFF_W-1:0] off_h, off_v;
    logic                    push, pop, q_ready, q_valid;
    logic [ENTRY_W-1:0]      push_entry, head_entry;

    rts_setup #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_setup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_busy    (busy),
        .o_thr     (thr),
        .o_src_w   (src_w),
        .o_src_h   (src_h),
        .o_disp_w  (disp_w),
        .o_disp_h  (disp_h),
        .o_scale_h (scale_h),
        .o_scale_v (scale_v),
        .o_off_h   (off_h),
        .o_off_v   (off_v)
    );

    rts_front #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_pix     (i_pix),
        .i_busy    (busy),
        .i_q_ready (q_ready),
        .i_thr     (thr),
        .i_src_w   (src_w),
        .i_src_h   (src_h),
        .i_scale_h (scale_h),
        .i_scale_v (scale_v),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    rts_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (head_entry)
    );

    rts_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (head_entry),
        .i_disp_w  (disp_w),
        .i_disp_h  (disp_h),
        .i_off_h   (off_h),
        .i_off_v   (off_v),
        .o_pop     (pop),
        .o_dot     (o_dot)
    );

endmodule

`default_nettype wire

>>> tb/sv/rts_checker.sv
// rts_checker: watches the pixel, dot and register channels of the threshold
// scaler, predicts every dot from its own copy of the registers and compares.
// Depends on rts_pkg and rts_if.
module rts_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rts_in_if    pix,
    rts_out_if   dot,
    rts_cfg_if   cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rts_pkg::*;

    localparam int MAX_DIM   = 1024;
    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               lit;
    } t_dot;

    t_dot dots_due[$];
    int   mismatches = 0;

    logic [DIM_REG_W-1:0] disp_w, disp_h, frame_w, frame_h;
    logic [MODE_W-1:0]    mode;
    logic [THR_W-1:0]     thresh;
    longint unsigned      step_h, step_v;
    int                   shift_h, shift_v;

    assign o_fail_count = mismatches;

    function automatic int unsigned clamp_dim(input logic [DIM_REG_W-1:0] v);
        if (v < 1) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    // offset that centers src*scale inside disp, in whole pixels
    function automatic int centre_gap(input int unsigned disp, input int unsigned src,
                                      input longint unsigned scale);
        longint unsigned full;
        longint unsigned used;
        full = longint'(disp) << FRAC_BITS;
        used = longint'(src) * scale;
        if (used >= full) return 0;
        return int'((full - used) >> (FRAC_BITS + 1));
    endfunction

    function automatic void rescale();
        longint unsigned dw, dh, sw, sh, fx, fy, m;
        dw = clamp_dim(disp_w);
        dh = clamp_dim(disp_h);
        sw = clamp_dim(frame_w);
        sh = clamp_dim(frame_h);
        fx = (dw << FRAC_BITS) / sw;
        fy = (dh << FRAC_BITS) / sh;
        if (mode == MODE_FILL) begin
            step_h  = fx;
            step_v  = fy;
            shift_h = 0;
            shift_v = 0;
        end else if (mode == MODE_FIT) begin
            m       = (fx < fy) ? fx : fy;
            step_h  = m;
            step_v  = m;
            shift_h = centre_gap(dw, sw, m);
            shift_v = centre_gap(dh, sh, m);
        end else begin
            // none, and the unused mode code
            step_h  = longint'(1) << FRAC_BITS;
            step_v  = longint'(1) << FRAC_BITS;
            shift_h = (int'(dw) - int'(sw)) / 2;
            shift_v = (int'(dh) - int'(sh)) / 2;
        end
    endfunction

    function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_DISPLAY_WIDTH:  disp_w  = val;
            REG_DISPLAY_HEIGHT: disp_h  = val;
            REG_SOURCE_WIDTH:   frame_w = val;
            REG_SOURCE_HEIGHT:  frame_h = val;
            REG_SCALE_MODE:     mode    = val[MODE_W-1:0];
            REG_LUMA_THRESHOLD: thresh  = val[THR_W-1:0];
            default:            return;
        endcase
        rescale();
    endfunction

    // returns 1 when the pixel lands on the display
    function automatic bit map_pixel(input logic [COORD_W-1:0] col,
                                     input logic [COORD_W-1:0] row,
                                     input logic [PIX_W-1:0] px, output t_dot d);
        longint          tx, ty;
        longint unsigned prod;
        int unsigned     r, g, b, lum;
        d = '0;
        if (col >= clamp_dim(frame_w) || row >= clamp_dim(frame_h)) return 0;
        prod = longint'(col) * step_h;
        tx   = longint'(shift_h) + longint'(prod >> FRAC_BITS);
        prod = longint'(row) * step_v;
        ty   = longint'(shift_v) + longint'(prod >> FRAC_BITS);
        if (tx < 0 || tx >= longint'(clamp_dim(disp_w))) return 0;
        if (ty < 0 || ty >= longint'(clamp_dim(disp_h))) return 0;
        r   = {px[15:11], 3'b000};
        g   = {px[10:5], 2'b00};
        b   = {px[4:0], 3'b000};
        lum = (r * 3 + g * 6 + b) / 10;
        d.col = tx[COORD_W-1:0];
        d.row = ty[COORD_W-1:0];
        d.lit = (lum > thresh);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_dot want;
        t_dot got;
        if (!i_rst_n) begin
            disp_w  = 11'd128;
            disp_h  = 11'd64;
            frame_w = 11'd128;
            frame_h = 11'd64;
            mode    = MODE_FIT;
            thresh  = 8'd128;
            rescale();
            dots_due.delete();
        end else begin
            if (dot.valid && dot.ready) begin
                got = '{dot.dst_col, dot.dst_row, dot.lit};
                if (dots_due.size() == 0) begin
                    $error("unexpected dot: dst_col %0d dst_row %0d lit %0d",
                           got.col, got.row, got.lit);
                    mismatches++;
                end else begin
                    want = dots_due.pop_front();
                    if (got.col !== want.col) begin
                        $error("dst_col: expected %0d, actual %0d", want.col, got.col);
                        mismatches++;
                    end
                    if (got.row !== want.row) begin
                        $error("dst_row: expected %0d, actual %0d", want.row, got.row);
                        mismatches++;
                    end
                    if (got.lit !== want.lit) begin
                        $error("lit: expected %0d, actual %0d", want.lit, got.lit);
                        mismatches++;
                    end
                end
            end
            if (cfg.valid && cfg.ready) write_reg(cfg.index, cfg.data);
            if (pix.valid && pix.ready) begin
                if (map_pixel(pix.src_col, pix.src_row, pix.rgb_pixel, want))
                    dots_due.push_back(want);
            end
        end
        o_pending <= dots_due.size();
    end

endmodule

>>> tb/sv/tb.sv
// tb: top of the threshold scaler testbench; drives pixels and register
// writes, toggles output backpressure and reports the verdict.
// Depends on rts_pkg, rts_if, rts_checker and rgb565_threshold_scaler.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rts_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 200;

    localparam logic [MODE_W-1:0]    MODE_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rts_in_if  pix ();
    rts_out_if dot ();
    rts_cfg_if cfg ();

    int fail_count;
    int pending;

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int hold_done = 0;
    int hold_left = 0;

    int unsigned frame_w = 128;
    int unsigned frame_h = 64;

    rgb565_threshold_scaler DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_dot   (dot),
        .i_cfg   (cfg)
    );

    rts_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pix          (pix),
        .dot          (dot),
        .cfg          (cfg),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // output backpressure; a requested hold-off is counted out here
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            dot.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_done) begin
            dot.ready <= 1'b0;
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
        end else begin
            dot.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic int unsigned span(input logic [DIM_REG_W-1:0] v);
        if (v < 1) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    function automatic logic [DIM_REG_W-1:0] pick_dim();
        case ($urandom_range(0, 11))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd1024;
            3:       return 11'd2047;
            4:       return 11'($urandom_range(1025, 2047));
            5, 6, 7: return 11'($urandom_range(1, 64));
            default: return 11'($urandom_range(1, 1024));
        endcase
    endfunction

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input logic [PIX_W-1:0] px);
        while ($urandom_range(0, 99) < idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid     <= 1'b1;
        pix.src_col   <= col;
        pix.src_row   <= row;
        pix.rgb_pixel <= px;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
    endtask

    // hold until every predicted dot is out, then let stray items clear
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        pix.valid <= 1'b0;
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        if (idx == REG_SOURCE_WIDTH)  frame_w = span(val);
        if (idx == REG_SOURCE_HEIGHT) frame_h = span(val);
    endtask

    task automatic random_setup(input int ph);
        logic [DIM_REG_W-1:0] d;
        logic [MODE_W-1:0]    m;
        if (ph == 1) begin
            set_register(REG_DISPLAY_WIDTH, 11'd1024);
            set_register(REG_DISPLAY_HEIGHT, 11'd1024);
            set_register(REG_SOURCE_WIDTH, 11'd1024);
            set_register(REG_SOURCE_HEIGHT, 11'd1024);
        end else if (ph == 2) begin
            set_register(REG_DISPLAY_WIDTH, 11'd1);
            set_register(REG_DISPLAY_HEIGHT, 11'd1);
            set_register(REG_SOURCE_WIDTH, 11'd1);
            set_register(REG_SOURCE_HEIGHT, 11'd1);
        end else begin
            d = pick_dim();
            set_register(REG_DISPLAY_WIDTH, d);
            d = pick_dim();
            set_register(REG_DISPLAY_HEIGHT, d);
            d = pick_dim();
            set_register(REG_SOURCE_WIDTH, d);
            d = pick_dim();
            set_register(REG_SOURCE_HEIGHT, d);
        end
        m = MODE_W'($urandom_range(0, 3));
        set_register(REG_SCALE_MODE, {9'($urandom_range(0, 511)), m});
        if (ph == 0)
            set_register(REG_LUMA_THRESHOLD, {3'b111, 8'd0});
        else if (ph == 7)
            set_register(REG_LUMA_THRESHOLD, {3'b000, 8'd255});
        else
            set_register(REG_LUMA_THRESHOLD, 11'($urandom_range(0, 2047)));
        if (ph == 4) set_register(REG_UNUSED_HI, 11'($urandom_range(0, 2047)));
    endtask

    initial begin
        logic [COORD_W-1:0] c, r;
        pix.valid     <= 1'b0;
        pix.src_col   <= '0;
        pix.src_row   <= '0;
        pix.rgb_pixel <= '0;
        cfg.valid     <= 1'b0;
        cfg.index     <= '0;
        cfg.data      <= '0;
        i_rst_n       <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setup: fit, 128x64 onto 128x64
        send_pixel(10'd0, 10'd0, 16'h0000);
        send_pixel(10'd127, 10'd63, 16'hFFFF);
        send_pixel(10'd128, 10'd0, 16'hFFFF);
        send_pixel(10'd0, 10'd64, 16'hFFFF);
        send_pixel(10'd1023, 10'd1023, 16'hFFFF);
        send_pixel(10'd5, 10'd7, 16'hF800);
        send_pixel(10'd6, 10'd8, 16'h07E0);
        send_pixel(10'd9, 10'd9, 16'h001F);

        // threshold edges: pure green sits at luminance 151
        set_register(REG_LUMA_THRESHOLD, 11'd150);
        send_pixel(10'd10, 10'd10, 16'h07E0);
        set_register(REG_LUMA_THRESHOLD, 11'd151);
        send_pixel(10'd11, 10'd11, 16'h07E0);
        set_register(REG_LUMA_THRESHOLD, 11'd255);
        send_pixel(10'd12, 10'd12, 16'hFFFF);
        set_register(REG_LUMA_THRESHOLD, 11'd0);
        send_pixel(10'd13, 10'd13, 16'h0020);

        // none mode with a source larger than the display: negative offsets
        set_register(REG_SOURCE_WIDTH, 11'd256);
        set_register(REG_SOURCE_HEIGHT, 11'd128);
        set_register(REG_SCALE_MODE, {9'd0, MODE_NONE});
        send_pixel(10'd0, 10'd0, 16'hFFFF);
        send_pixel(10'd64, 10'd32, 16'hFFFF);
        send_pixel(10'd191, 10'd95, 16'h8410);
        send_pixel(10'd192, 10'd96, 16'hFFFF);

        // unused mode code behaves as none; unused indexes are ignored
        set_register(REG_SCALE_MODE, {9'd0, MODE_SPARE});
        set_register(REG_UNUSED_LO, 11'h7FF);
        send_pixel(10'd100, 10'd50, 16'h7BEF);

        // dimension clamps: 2047 to the maximum, 0 to one
        set_register(REG_DISPLAY_WIDTH, 11'd2047);
        set_register(REG_DISPLAY_HEIGHT, 11'd0);
        set_register(REG_SOURCE_WIDTH, 11'd1024);
        set_register(REG_SOURCE_HEIGHT, 11'd1);
        set_register(REG_SCALE_MODE, {9'd0, MODE_FILL});
        send_pixel(10'd1023, 10'd0, 16'hFFFF);
        send_pixel(10'd0, 10'd0, 16'hFFFF);

        // fit onto a one-column display, centered vertically
        set_register(REG_DISPLAY_WIDTH, 11'd1);
        set_register(REG_DISPLAY_HEIGHT, 11'd1024);
        set_register(REG_SOURCE_HEIGHT, 11'd0);
        set_register(REG_SCALE_MODE, {9'd0, MODE_FIT});
        send_pixel(10'd1023, 10'd0, 16'hFFFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            random_setup(ph);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == 40) hold_reqs <= hold_reqs + 1;
                if (ph == 5 && n == 100) begin
                    pix.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                if ($urandom_range(0, 9) < 8) begin
                    c = COORD_W'($urandom_range(0, frame_w - 1));
                    r = COORD_W'($urandom_range(0, frame_h - 1));
                end else begin
                    c = COORD_W'($urandom_range(0, 1023));
                    r = COORD_W'($urandom_range(0, 1023));
                end
                send_pixel(c, r, PIX_W'($urandom_range(0, 65535)));
            end
        end

        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/rts_pkg.sv
hw/rtl/rts_if.sv
hw/rtl/rts_divider.sv
hw/rtl/rts_setup.sv
hw/rtl/rts_front.sv
hw/rtl/rts_queue.sv
hw/rtl/rts_back.sv
hw/rtl/rgb565_threshold_scaler.sv
tb/sv/rts_checker.sv
tb/sv/tb.sv
